>>> rtl/resource_credit_admission_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the resource credit admission queue
// Shared concurrent property forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_CREDIT_ADMISSION_QUEUE_UNIT_ASSERT_SVH
`define RESOURCE_CREDIT_ADMISSION_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define RCAQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCAQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rcaq_pkg.sv
// ----------------------------------------------------------------------------
// rcaq_pkg
// Types, codes and defaults shared by the admission queue modules.
// ----------------------------------------------------------------------------
package rcaq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_COUNT_BITS  = 16;
   localparam int LIMIT_BITS      = 16;

   // request actions
   localparam logic [1:0] ACT_ACQUIRE  = 2'd0;
   localparam logic [1:0] ACT_RELEASE  = 2'd1;
   localparam logic [1:0] ACT_ENQUEUE  = 2'd2;
   localparam logic [1:0] ACT_DISPATCH = 2'd3;

   // resource mask bits
   localparam int RES_SQL_BIT = 0;
   localparam int RES_FD_BIT  = 1;

   // response status codes
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_REFUSED    = 3'd1;
   localparam logic [2:0] ST_RELEASED   = 3'd2;
   localparam logic [2:0] ST_UNDERFLOW  = 3'd3;
   localparam logic [2:0] ST_QUEUED     = 3'd4;
   localparam logic [2:0] ST_QUEUE_FULL = 3'd5;
   localparam logic [2:0] ST_DISPATCHED = 3'd6;

   // register indexes
   localparam logic CSR_SQL_LIMIT = 1'b0;
   localparam logic CSR_FD_LIMIT  = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  need_mask;
      logic [15:0] msg_type;
      logic [63:0] msg_handle;
      logic [63:0] request_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  underflow_mask;
      logic [15:0] sql_in_use;
      logic [15:0] fd_in_use;
      logic        out_valid;
      logic [1:0]  out_mask;
      logic [15:0] out_type;
      logic [63:0] out_handle;
      logic [63:0] out_id;
      logic [63:0] out_serial;
   } rsp_type;

   // one deferred table entry
   typedef struct packed {
      logic [1:0]  mask;
      logic [15:0] msg_type;
      logic [63:0] handle;
      logic [63:0] id;
      logic [63:0] serial;
   } entry_type;

   // top -> queue command
   typedef struct packed {
      logic       enq;
      logic       disp;
      logic [1:0] dmask;
      entry_type  entry;
   } q_cmd_type;

   // queue -> top status
   typedef struct packed {
      logic      busy;
      logic      full;
      logic      done;
      logic      found;
      entry_type entry;
   } q_stat_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_SCAN,
      Q_SHIFT,
      Q_DONE
   } q_state_type;

endpackage

>>> rtl/rcaq_queue.sv
// ----------------------------------------------------------------------------
// rcaq_queue
// Age-ordered deferred table in a single-port-read memory. Enqueue appends at
// the fill point; dispatch scans one entry a cycle, then closes the gap by
// moving the younger entries down one slot a cycle.
// ----------------------------------------------------------------------------
module rcaq_queue #(
   parameter int QUEUE_DEPTH = rcaq_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rcaq_pkg::q_cmd_type    q_cmd,
   output rcaq_pkg::q_stat_type   q_stat
);
   import rcaq_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SEQ_W  = FILL_W + 1;

   q_state_type        state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic [1:0]         dmask_ff, dmask_in;
   logic               found_ff, found_in;
   entry_type          hit_ff, hit_in;
   entry_type          rd_data_ff;
   entry_type          entry_mem [QUEUE_DEPTH];

   logic [SEQ_W-1:0]   idx_nx1, idx_nx2, fill_ext, rd_next;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               wr_en;
   entry_type          wr_data;
   logic               match, full, more1, more2;

   assign idx_nx1  = SEQ_W'(idx_ff) + SEQ_W'(1);
   assign idx_nx2  = SEQ_W'(idx_ff) + SEQ_W'(2);
   assign fill_ext = SEQ_W'(fill_ff);
   assign more1    = idx_nx1 < fill_ext;
   assign more2    = idx_nx2 < fill_ext;
   assign full     = fill_ff == FILL_W'(QUEUE_DEPTH);
   // mask 0 fits any nonzero dispatch mask
   assign match    = (rd_data_ff.mask & dmask_ff) == rd_data_ff.mask;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         Q_IDLE: begin
            if (q_cmd.disp) begin
               state_in = (fill_ff == '0) ? Q_DONE : Q_SCAN;
            end
         end
         Q_SCAN: begin
            if (match) begin
               state_in = more1 ? Q_SHIFT : Q_DONE;
            end else begin
               state_in = more1 ? Q_SCAN : Q_DONE;
            end
         end
         Q_SHIFT: begin
            state_in = more2 ? Q_SHIFT : Q_DONE;
         end
         Q_DONE: begin
            state_in = Q_IDLE;
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      dmask_in = dmask_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      rd_next  = '0;
      wr_en    = 1'b0;
      wr_addr  = fill_ff[IDX_W-1:0];
      wr_data  = q_cmd.entry;
      unique case (state_ff)
         Q_IDLE: begin
            idx_in   = '0;
            found_in = 1'b0;
            dmask_in = q_cmd.dmask;
            if (q_cmd.enq && !full) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         Q_SCAN: begin
            rd_next = idx_nx1;
            if (match) begin
               found_in = 1'b1;
               hit_in   = rd_data_ff;
            end else begin
               idx_in = idx_nx1[FILL_W-1:0];
            end
         end
         Q_SHIFT: begin
            // rd_data_ff holds the entry one slot above idx_ff
            rd_next = idx_nx2;
            wr_en   = 1'b1;
            wr_addr = idx_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            idx_in  = idx_nx1[FILL_W-1:0];
         end
         Q_DONE: begin
            if (found_ff) begin
               fill_in = fill_ff - FILL_W'(1);
            end
         end
         default: begin
         end
      endcase
      rd_addr = (rd_next < SEQ_W'(QUEUE_DEPTH)) ? rd_next[IDX_W-1:0] : '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
         fill_ff  <= '0;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dmask_ff <= dmask_in;
      hit_ff   <= hit_in;
   end

   // entry table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign q_stat.busy  = state_ff != Q_IDLE;
   assign q_stat.full  = full;
   assign q_stat.done  = state_ff == Q_DONE;
   assign q_stat.found = found_ff;
   assign q_stat.entry = hit_ff;

`include "resource_credit_admission_queue_unit_assert.svh"

   `RCAQ_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(QUEUE_DEPTH), "fill beyond depth")
   `RCAQ_ASSERT_NOW(a_shift_found, clock, reset, state_ff == Q_SHIFT, found_ff, "shift without a hit")
   `RCAQ_ASSERT_NEXT(a_enq_fill, clock, reset, state_ff == Q_IDLE && q_cmd.enq && !full, fill_ff == $past(fill_ff) + FILL_W'(1), "enqueue did not grow fill")

endmodule

>>> rtl/resource_credit_admission_queue_unit.sv
// ----------------------------------------------------------------------------
// resource_credit_admission_queue_unit
// SQL/FD credit counters with limits, plus a deferred request table that
// dispatches the oldest entry whose needs fit the dispatch mask.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Transfer
//   request   start, busy, req_data          start && !busy at clock edge
//   response  rsp_valid, rsp_data            rsp_valid, one cycle, no stall
//   control   csr_we, csr_addr, csr_wdata    csr_we at clock edge
//
// Acquire, release, enqueue and a dispatch with no resource available answer
// in the cycle after the transfer; the next request may follow in the next cycle.
// Any other dispatch holds busy while the table scans and then closes the gap,
// and its response shows in the first cycle after busy falls: the table has one
// read port, so the scan reads and the gap closing moves one entry a cycle.
// reset is synchronous, active high; it empties the table and clears counters
// and limits. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
module resource_credit_admission_queue_unit #(
   parameter int QUEUE_DEPTH = rcaq_pkg::DEF_QUEUE_DEPTH,
   parameter int COUNT_BITS  = rcaq_pkg::DEF_COUNT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rcaq_pkg::req_type req_data,
   output logic              rsp_valid,
   output rcaq_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [15:0]       csr_wdata
);
   import rcaq_pkg::*;

   localparam int CMP_W = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [LIMIT_BITS-1:0] sql_limit_ff, fd_limit_ff;
   logic [COUNT_BITS-1:0] sql_count_ff, sql_count_in;
   logic [COUNT_BITS-1:0] fd_count_ff, fd_count_in;
   logic [63:0]           serial_ff, serial_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CMP_W-1:0]      sql_ext, fd_ext, sql_lim_ext, fd_lim_ext;
   logic [CMP_W-1:0]      sql_new_ext, fd_new_ext;
   logic                  sql_avail, fd_avail, sql_block, fd_block;
   logic                  req_accept, want_sql, want_fd;
   logic [1:0]            avail_mask, disp_mask, umask;
   logic [63:0]           serial_nx;
   q_cmd_type             q_cmd;
   q_stat_type            q_stat;

   assign req_accept = start && !busy;
   assign want_sql   = req_data.need_mask[RES_SQL_BIT];
   assign want_fd    = req_data.need_mask[RES_FD_BIT];

   // limit checks, 0 limit means unlimited
   assign sql_ext     = CMP_W'(sql_count_ff);
   assign fd_ext      = CMP_W'(fd_count_ff);
   assign sql_lim_ext = CMP_W'(sql_limit_ff);
   assign fd_lim_ext  = CMP_W'(fd_limit_ff);
   assign sql_avail   = (sql_limit_ff == '0) || (sql_ext < sql_lim_ext);
   assign fd_avail    = (fd_limit_ff == '0) || (fd_ext < fd_lim_ext);
   assign sql_block   = want_sql && (!sql_avail || (&sql_count_ff));
   assign fd_block    = want_fd && (!fd_avail || (&fd_count_ff));

   assign avail_mask = {fd_avail, sql_avail};
   assign disp_mask  = (req_data.need_mask != 2'b00) ? req_data.need_mask : avail_mask;
   assign serial_nx  = serial_ff + 64'd1;

   // queue commands
   always_comb begin
      q_cmd.enq          = req_accept && (req_data.action == ACT_ENQUEUE);
      q_cmd.disp         = req_accept && (req_data.action == ACT_DISPATCH)
                           && (disp_mask != 2'b00);
      q_cmd.dmask        = disp_mask;
      q_cmd.entry.mask     = req_data.need_mask;
      q_cmd.entry.msg_type = req_data.msg_type;
      q_cmd.entry.handle   = req_data.msg_handle;
      q_cmd.entry.id       = req_data.request_id;
      q_cmd.entry.serial   = serial_nx;
   end

   rcaq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_cmd  (q_cmd),
      .q_stat (q_stat)
   );

   // counter updates and response build
   always_comb begin
      sql_count_in = sql_count_ff;
      fd_count_in  = fd_count_ff;
      serial_in    = serial_ff;
      umask        = 2'b00;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = ST_RELEASED;
      if (req_accept) begin
         case (req_data.action)
            ACT_ACQUIRE: begin
               rsp_valid_in = 1'b1;
               if (sql_block || fd_block) begin
                  rsp_in.status = ST_REFUSED;
               end else begin
                  rsp_in.status = ST_GRANTED;
                  if (want_sql) sql_count_in = sql_count_ff + COUNT_BITS'(1);
                  if (want_fd) fd_count_in = fd_count_ff + COUNT_BITS'(1);
               end
            end
            ACT_RELEASE: begin
               rsp_valid_in = 1'b1;
               if (want_sql) begin
                  if (sql_count_ff != '0) sql_count_in = sql_count_ff - COUNT_BITS'(1);
                  else umask[RES_SQL_BIT] = 1'b1;
               end
               if (want_fd) begin
                  if (fd_count_ff != '0) fd_count_in = fd_count_ff - COUNT_BITS'(1);
                  else umask[RES_FD_BIT] = 1'b1;
               end
               rsp_in.underflow_mask = umask;
               rsp_in.status = (umask != 2'b00) ? ST_UNDERFLOW : ST_RELEASED;
            end
            ACT_ENQUEUE: begin
               rsp_valid_in = 1'b1;
               if (q_stat.full) begin
                  rsp_in.status = ST_QUEUE_FULL;
               end else begin
                  serial_in         = serial_nx;
                  rsp_in.status     = ST_QUEUED;
                  rsp_in.out_serial = serial_nx;
               end
            end
            default: begin
               // dispatch with nothing available answers at once
               rsp_valid_in = disp_mask == 2'b00;
            end
         endcase
      end else if (q_stat.done) begin
         rsp_valid_in = 1'b1;
         if (q_stat.found) begin
            rsp_in.status     = ST_DISPATCHED;
            rsp_in.out_valid  = 1'b1;
            rsp_in.out_mask   = q_stat.entry.mask;
            rsp_in.out_type   = q_stat.entry.msg_type;
            rsp_in.out_handle = q_stat.entry.handle;
            rsp_in.out_id     = q_stat.entry.id;
            rsp_in.out_serial = q_stat.entry.serial;
         end
      end
      sql_new_ext       = CMP_W'(sql_count_in);
      fd_new_ext        = CMP_W'(fd_count_in);
      rsp_in.sql_in_use = sql_new_ext[15:0];
      rsp_in.fd_in_use  = fd_new_ext[15:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sql_limit_ff <= '0;
         fd_limit_ff  <= '0;
         sql_count_ff <= '0;
         fd_count_ff  <= '0;
         serial_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sql_count_ff <= sql_count_in;
         fd_count_ff  <= fd_count_in;
         serial_ff    <= serial_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SQL_LIMIT: sql_limit_ff <= csr_wdata;
               CSR_FD_LIMIT:  fd_limit_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy      = q_stat.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "resource_credit_admission_queue_unit_assert.svh"

   `RCAQ_ASSERT_NOW(a_done_no_accept, clock, reset, q_stat.done, !req_accept,
                    "accept during dispatch finish")
   `RCAQ_ASSERT_NEXT(a_rsp_source, clock, reset, !req_accept && !q_stat.done,
                     !rsp_valid_ff, "response without a cause")
   `RCAQ_ASSERT_NOW(a_disp_payload, clock, reset,
                    rsp_valid_ff && rsp_ff.status == ST_DISPATCHED,
                    rsp_ff.out_valid, "dispatch without entry")

endmodule
